// ===== hw/rtl/scwd_pkg.sv =====
// ----------------------------------------------------------------------------
// scwd_pkg
// Shared types, result kinds and the curve format table for the stepper
// command word decoder.
// ----------------------------------------------------------------------------
package scwd_pkg;

	typedef enum logic [2:0] {
		KIND_SETTINGS = 3'd0,
		KIND_MOVE     = 3'd1,
		KIND_DELAY    = 3'd2,
		KIND_CURVE    = 3'd3,
		KIND_MARKER   = 3'd4,
		KIND_INVALID  = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic exec;
		logic advance;
	} cmd_t;

	typedef struct packed {
		logic last;
	} sts_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] len;
		logic [3:0] bits;
		logic [4:0] lshift;
		logic [2:0] asr;
	} fmt_t;

	// leading ones of the upper half, 16 when all set
	function automatic logic [4:0] lead_ones(input logic [15:0] hi);
		logic [4:0] n;
		logic       done;
		n    = 5'd16;
		done = 1'b0;
		for (int i = 0; i < 16; i++) begin
			if (!done && !hi[15-i]) begin
				n    = 5'(i);
				done = 1'b1;
			end
		end
		return n;
	endfunction

	function automatic fmt_t curve_fmt(input logic [4:0] n);
		fmt_t f;
		f = '0;
		unique case (n)
			5'd3:  f = '{1'b1, 4'd9, 4'd3, 5'd5,  3'd5};
			5'd6:  f = '{1'b1, 4'd8, 4'd3, 5'd8,  3'd5};
			5'd2:  f = '{1'b1, 4'd7, 4'd4, 5'd4,  3'd4};
			5'd5:  f = '{1'b1, 4'd6, 4'd4, 5'd8,  3'd4};
			5'd4:  f = '{1'b1, 4'd5, 4'd5, 5'd7,  3'd3};
			5'd10: f = '{1'b1, 4'd4, 4'd5, 5'd12, 3'd3};
			5'd9:  f = '{1'b1, 4'd3, 4'd7, 5'd11, 3'd1};
			5'd14: f = '{1'b1, 4'd2, 4'd8, 5'd16, 3'd0};
			default: f = '0;
		endcase
		return f;
	endfunction

endpackage

// ===== hw/rtl/scwd_ctrl.sv =====
// ----------------------------------------------------------------------------
// scwd_ctrl
// Sequencer: takes a word, runs the decode step, then hands out result beats
// until the last one is taken.
// ----------------------------------------------------------------------------
module scwd_ctrl import scwd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	output cmd_t cmd,
	input  sts_t sts
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = ST_EMIT;
			end
			ST_EMIT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					if (sts.last) begin
						state_d = ST_IDLE;
					end else begin
						cmd.advance = 1'b1;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ===== hw/rtl/scwd_dp.sv =====
// ----------------------------------------------------------------------------
// scwd_dp
// Datapath: command word register, motion state, result kind and the curve
// entry shifter.
// ----------------------------------------------------------------------------
module scwd_dp import scwd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output sts_t              sts,
	input  logic [31:0]       command_word,
	output logic [2:0]        kind,
	output logic [3:0]        marker_code,
	output logic [11:0]       pulse_count,
	output logic [11:0]       target_rate,
	output logic [11:0]       current_rate,
	output logic [7:0]        accel_rate,
	output logic              slowing,
	output logic [15:0]       delay_us,
	output logic [2:0]        microstep,
	output logic              direction,
	output logic signed [7:0] curve_value,
	output logic              last
);

	logic [31:0] word_q;
	logic [31:0] sh_q;
	logic [3:0]  bits_q;
	logic [2:0]  asr_q;
	logic [3:0]  code_q;
	logic [3:0]  idx_q;

	kind_t       kind_q;
	logic [11:0] current_q;
	logic [11:0] target_q;
	logic [11:0] pulse_q;
	logic [15:0] delay_q;
	logic [7:0]  accel_q;
	logic        slowing_q;
	logic [2:0]  microstep_q;
	logic        direction_q;
	logic [3:0]  curve_count_q;

	logic        is_marker;
	fmt_t        fmt;
	logic signed [7:0] top;

	assign is_marker = (word_q[31:16] == 16'hffff) && (word_q[15:5] == 11'b11111111110);
	assign fmt       = curve_fmt(lead_ones(word_q[31:16]));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			word_q <= command_word;
		end
		if (cmd.exec) begin
			sh_q   <= word_q << fmt.lshift;
			bits_q <= fmt.bits;
			asr_q  <= fmt.asr;
			code_q <= (word_q[31] && is_marker) ? word_q[3:0] : 4'd0;
		end else if (cmd.advance) begin
			sh_q <= sh_q << bits_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q        <= KIND_SETTINGS;
			idx_q         <= '0;
			current_q     <= '0;
			target_q      <= '0;
			pulse_q       <= '0;
			delay_q       <= '0;
			accel_q       <= '0;
			slowing_q     <= 1'b0;
			microstep_q   <= '0;
			direction_q   <= 1'b0;
			curve_count_q <= '0;
		end else if (cmd.exec) begin
			idx_q <= '0;
			if (!word_q[31]) begin
				accel_q       <= 8'd0;
				curve_count_q <= 4'd0;
				if (word_q[30]) begin
					kind_q      <= KIND_SETTINGS;
					accel_q     <= word_q[7:0];
					current_q   <= word_q[27:16];
					microstep_q <= word_q[15:13];
					direction_q <= word_q[28];
				end else begin
					pulse_q <= word_q[11:0];
					if (word_q[11:0] == 12'd0) begin
						kind_q  <= KIND_DELAY;
						delay_q <= {word_q[15:13], word_q[28:16]};
					end else begin
						kind_q      <= KIND_MOVE;
						target_q    <= word_q[27:16];
						slowing_q   <= (word_q[27:16] < current_q);
						microstep_q <= word_q[15:13];
						direction_q <= word_q[28];
					end
				end
			end else if (is_marker) begin
				kind_q <= KIND_MARKER;
			end else if (fmt.ok) begin
				kind_q        <= KIND_CURVE;
				pulse_q       <= 12'd0;
				curve_count_q <= fmt.len;
			end else begin
				kind_q <= KIND_INVALID;
			end
		end else if (cmd.advance) begin
			idx_q <= idx_q + 4'd1;
		end
	end

	assign top      = $signed(sh_q[31:24]) >>> asr_q;
	assign sts.last = (kind_q != KIND_CURVE) || (({1'b0, idx_q} + 5'd1) == {1'b0, curve_count_q});

	assign kind         = kind_q;
	assign marker_code  = code_q;
	assign pulse_count  = pulse_q;
	assign target_rate  = target_q;
	assign current_rate = current_q;
	assign accel_rate   = accel_q;
	assign slowing      = slowing_q;
	assign delay_us     = delay_q;
	assign microstep    = microstep_q;
	assign direction    = direction_q;
	assign curve_value  = (kind_q == KIND_CURVE) ? top : 8'sd0;
	assign last         = sts.last;

endmodule

// ===== hw/rtl/stepper_command_word_decoder.sv =====
// ----------------------------------------------------------------------------
// stepper_command_word_decoder
// Decodes 32-bit motion command words, keeps the axis motion state and
// reports it with each result beat; curve words yield one beat per entry.
//
//   channel  direction  handshake             payload
//   in       sink       in_valid / in_ready   command_word
//   out      source     out_valid / out_ready kind .. last (12 fields)
//
// A word passes the accept, decode and present steps of the sequencer before
// its first result beat; a curve word then gives one entry per cycle while
// the output does not stall, 2 to 9 in all.
// arst_n clears the sequencer and all motion state to zero.
// Output stalls hold the current beat; no new word is taken until the last
// beat of the previous one is accepted.
// ----------------------------------------------------------------------------
module stepper_command_word_decoder import scwd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [31:0]       command_word,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [2:0]        kind,
	output logic [3:0]        marker_code,
	output logic [11:0]       pulse_count,
	output logic [11:0]       target_rate,
	output logic [11:0]       current_rate,
	output logic [7:0]        accel_rate,
	output logic              slowing,
	output logic [15:0]       delay_us,
	output logic [2:0]        microstep,
	output logic              direction,
	output logic signed [7:0] curve_value,
	output logic              last
);

	cmd_t cmd;
	sts_t sts;

	scwd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	scwd_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.command_word (command_word),
		.kind         (kind),
		.marker_code  (marker_code),
		.pulse_count  (pulse_count),
		.target_rate  (target_rate),
		.current_rate (current_rate),
		.accel_rate   (accel_rate),
		.slowing      (slowing),
		.delay_us     (delay_us),
		.microstep    (microstep),
		.direction    (direction),
		.curve_value  (curve_value),
		.last         (last)
	);

endmodule

// ===== sim/scwd_checker.sv =====
// ----------------------------------------------------------------------------
// scwd_checker
// Watches both channels of the stepper command word decoder. Keeps its own
// copy of the axis motion state, works out the result beats of each accepted
// command word, and compares every output beat, field by field, with the
// oldest beat still expected.
// ----------------------------------------------------------------------------
module scwd_checker import scwd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_ready,
	input  logic [31:0]       command_word,
	input  logic              out_valid,
	input  logic              out_ready,
	input  logic [2:0]        kind,
	input  logic [3:0]        marker_code,
	input  logic [11:0]       pulse_count,
	input  logic [11:0]       target_rate,
	input  logic [11:0]       current_rate,
	input  logic [7:0]        accel_rate,
	input  logic              slowing,
	input  logic [15:0]       delay_us,
	input  logic [2:0]        microstep,
	input  logic              direction,
	input  logic signed [7:0] curve_value,
	input  logic              last,
	output int                mismatches,
	output int                words_seen,
	output int                curve_words,
	output int                beats_seen,
	output int                beats_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		kind_t              kind;
		logic [3:0]         marker_code;
		logic [11:0]        pulse_count;
		logic [11:0]        target_rate;
		logic [11:0]        current_rate;
		logic [7:0]         accel_rate;
		logic               slowing;
		logic [15:0]        delay_us;
		logic [2:0]         microstep;
		logic               direction;
		logic signed [7:0]  curve_value;
		logic               last;
	} beat_t;

	beat_t expected_beats[$];

	logic [11:0] cur_rate  = '0;
	logic [11:0] tgt_rate  = '0;
	logic [11:0] pulses    = '0;
	logic [15:0] delay     = '0;
	logic [7:0]  accel     = '0;
	logic        slow      = 1'b0;
	logic [2:0]  ustep     = '0;
	logic        dir       = 1'b0;
	logic [3:0]  curve_len = '0;

	int n_bad     = 0;
	int n_words   = 0;
	int n_curves  = 0;
	int n_beats   = 0;
	int n_pending = 0;

	assign mismatches    = n_bad;
	assign words_seen    = n_words;
	assign curve_words   = n_curves;
	assign beats_seen    = n_beats;
	assign beats_pending = n_pending;

	function automatic beat_t motion_beat(input kind_t k, input logic [3:0] code,
			input logic signed [7:0] cv, input logic lst);
		return '{k, code, pulses, tgt_rate, cur_rate, accel, slow, delay, ustep, dir,
			cv, lst};
	endfunction

	function automatic string show(input beat_t b);
		return $sformatf({"kind=%0d code=%0h pulses=%0d target=%0d current=%0d ",
			"accel=%0d slow=%0b delay=%0d ustep=%0d dir=%0b curve=%0d last=%0b"},
			b.kind, b.marker_code, b.pulse_count, b.target_rate, b.current_rate,
			b.accel_rate, b.slowing, b.delay_us, b.microstep, b.direction,
			b.curve_value, b.last);
	endfunction

	task automatic decode_word(input logic [31:0] w);
		logic [15:0]       lo;
		logic [15:0]       hi;
		int                ones;
		int                len;
		int                bits;
		logic [31:0]       mask;
		logic [31:0]       sign_bit;
		logic [31:0]       v;
		logic [31:0]       e;
		logic signed [7:0] vals [9];
		lo = w[15:0];
		hi = w[31:16];
		if (!w[31]) begin
			accel     = '0;
			curve_len = '0;
			if (w[30]) begin
				accel    = lo[7:0];
				cur_rate = hi[11:0];
				ustep    = lo[15:13];
				dir      = w[28];
				expected_beats.push_back(motion_beat(KIND_SETTINGS, 4'h0, 8'sd0, 1'b1));
			end else begin
				pulses = lo[11:0];
				if (pulses == 12'd0) begin
					delay = {lo[15:13], hi[12:0]};
					expected_beats.push_back(motion_beat(KIND_DELAY, 4'h0, 8'sd0, 1'b1));
				end else begin
					tgt_rate = hi[11:0];
					slow     = (tgt_rate < cur_rate);
					ustep    = lo[15:13];
					dir      = w[28];
					expected_beats.push_back(motion_beat(KIND_MOVE, 4'h0, 8'sd0, 1'b1));
				end
			end
		end else if (hi == 16'hFFFF && lo[15:5] == 11'b111_1111_1110) begin
			expected_beats.push_back(motion_beat(KIND_MARKER, lo[3:0], 8'sd0, 1'b1));
		end else begin
			ones = 0;
			while (ones < 32 && w[31-ones])
				ones++;
			case (ones)
				3:       begin len = 9; bits = 3; end
				6:       begin len = 8; bits = 3; end
				2:       begin len = 7; bits = 4; end
				5:       begin len = 6; bits = 4; end
				4:       begin len = 5; bits = 5; end
				10:      begin len = 4; bits = 5; end
				9:       begin len = 3; bits = 7; end
				14:      begin len = 2; bits = 8; end
				default: begin len = 0; bits = 0; end
			endcase
			if (len == 0) begin
				expected_beats.push_back(motion_beat(KIND_INVALID, 4'h0, 8'sd0, 1'b1));
			end else begin
				mask     = (32'd1 << bits) - 32'd1;
				sign_bit = (mask + 32'd1) >> 1;
				v        = w;
				for (int i = len - 1; i >= 0; i--) begin
					e = v & mask;
					if ((e & sign_bit) != 0)
						e = e | ~mask;
					vals[i] = e[7:0];
					v = v >> bits;
				end
				pulses    = '0;
				curve_len = 4'(len);
				n_curves++;
				for (int i = 0; i < len; i++)
					expected_beats.push_back(motion_beat(KIND_CURVE, 4'h0, vals[i],
						i == len - 1));
			end
		end
	endtask

	always @(posedge clk) begin
		beat_t got;
		beat_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got = '{kind_t'(kind), marker_code, pulse_count, target_rate, current_rate,
					accel_rate, slowing, delay_us, microstep, direction, curve_value, last};
				n_beats++;
				if (expected_beats.size() == 0) begin
					n_bad++;
					if (n_bad <= 10)
						$display("%0t: result beat with nothing expected: %s", $time,
							show(got));
				end else begin
					want = expected_beats.pop_front();
					if (got !== want) begin
						n_bad++;
						if (n_bad <= 10) begin
							$display("%0t: mismatch on result beat %0d", $time, n_beats);
							$display("  expected %s", show(want));
							$display("  actual   %s", show(got));
						end
					end
				end
			end
			if (in_valid && in_ready) begin
				n_words++;
				decode_word(command_word);
			end
			n_pending = expected_beats.size();
		end
	end

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Drives command words into the stepper command word decoder: a directed
// set covering field extremes, every word type, marker near misses, each
// curve format and invalid curve prefixes, then random words weighted toward
// well-formed commands. Both channels idle at random. A checker beside the
// block predicts and compares; this module reports the verdict.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT   = 2000;
	localparam int RANDOM_WORDS = 346;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic [31:0]       command_word;
	logic              out_valid;
	logic              out_ready;
	logic [2:0]        kind;
	logic [3:0]        marker_code;
	logic [11:0]       pulse_count;
	logic [11:0]       target_rate;
	logic [11:0]       current_rate;
	logic [7:0]        accel_rate;
	logic              slowing;
	logic [15:0]       delay_us;
	logic [2:0]        microstep;
	logic              direction;
	logic signed [7:0] curve_value;
	logic              last;

	int mismatches;
	int words_seen;
	int curve_words;
	int beats_seen;
	int beats_pending;
	int idle_cycles;
	int send_calm;

	int curve_ones   [8] = '{2, 3, 4, 5, 6, 9, 10, 14};
	int invalid_ones [7] = '{1, 7, 8, 11, 12, 13, 15};

	always #10 clk = ~clk;

	stepper_command_word_decoder dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.command_word (command_word),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.kind         (kind),
		.marker_code  (marker_code),
		.pulse_count  (pulse_count),
		.target_rate  (target_rate),
		.current_rate (current_rate),
		.accel_rate   (accel_rate),
		.slowing      (slowing),
		.delay_us     (delay_us),
		.microstep    (microstep),
		.direction    (direction),
		.curve_value  (curve_value),
		.last         (last)
	);

	scwd_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.command_word  (command_word),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.kind          (kind),
		.marker_code   (marker_code),
		.pulse_count   (pulse_count),
		.target_rate   (target_rate),
		.current_rate  (current_rate),
		.accel_rate    (accel_rate),
		.slowing       (slowing),
		.delay_us      (delay_us),
		.microstep     (microstep),
		.direction     (direction),
		.curve_value   (curve_value),
		.last          (last),
		.mismatches    (mismatches),
		.words_seen    (words_seen),
		.curve_words   (curve_words),
		.beats_seen    (beats_seen),
		.beats_pending (beats_pending)
	);

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		else
			return $urandom_range(20, 60);
	endfunction

	// n leading ones, a zero below them, then fill
	function automatic logic [31:0] prefixed_word(input int n, input logic [31:0] fill);
		return ~(32'hFFFF_FFFF >> n) | (fill & (32'hFFFF_FFFF >> (n + 1)));
	endfunction

	function automatic logic [31:0] random_word();
		int r;
		r = $urandom_range(0, 99);
		if (r < 15)
			return {2'b01, 30'($urandom)};
		else if (r < 40)
			return {2'b00, 30'($urandom)};
		else if (r < 50)
			return {2'b00, 30'($urandom)} & 32'hFFFF_F000;
		else if (r < 58)
			return {16'hFFFF, 11'b111_1111_1110, 5'($urandom)};
		else if (r < 88)
			return prefixed_word(curve_ones[$urandom_range(0, 7)], $urandom);
		else if (r < 93)
			return prefixed_word(invalid_ones[$urandom_range(0, 6)], $urandom);
		else if (r < 95)
			return prefixed_word($urandom_range(16, 32), $urandom);
		else
			return $urandom;
	endfunction

	task automatic send_word(input logic [31:0] w);
		int gap;
		if (send_calm > 0) begin
			send_calm--;
			gap = 0;
		end else begin
			gap = pick_gap();
			if ($urandom_range(0, 29) == 0)
				send_calm = 25;
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid     <= 1'b1;
		command_word <= w;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
	endtask

	initial begin : ready_side
		int stall;
		int ready_calm;
		out_ready  = 1'b0;
		ready_calm = 0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(negedge clk);
			if (ready_calm > 0) begin
				ready_calm--;
			end else begin
				stall = pick_gap();
				if ($urandom_range(0, 39) == 0)
					ready_calm = 30;
				if (stall > 0) begin
					out_ready <= 1'b0;
					repeat (stall) @(negedge clk);
				end
			end
		end
	end

	initial begin : watchdog
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Timeout after %0d cycles with no beat moving", IDLE_LIMIT);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin
		in_valid     = 1'b0;
		command_word = '0;
		arst_n       = 1'b0;
		send_calm    = 0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		send_word(32'h5FFF_FFFF);
		send_word(32'h4000_0000);
		send_word(32'h1FFF_FFFF);
		send_word(32'h4FFF_0000);
		send_word(32'h0001_0001);
		send_word(32'h0000_0FFF);
		send_word(32'h3FFF_E000);
		send_word(32'h0000_0000);
		send_word(32'hFFFF_FFC0);
		send_word(32'hFFFF_FFDF);
		send_word(32'hFFFF_FFE0);
		foreach (curve_ones[i])
			send_word(prefixed_word(curve_ones[i], (i % 2) ? 32'hAAAA_AAAA : 32'hFFFF_FFFF));
		send_word(prefixed_word(14, 32'h0000_0000));
		send_word(prefixed_word(1, 32'h1234_5678));
		send_word(prefixed_word(7, 32'h00FF_00FF));
		send_word(prefixed_word(16, 32'h0000_0000));
		send_word(32'hFFFF_FFFF);

		repeat (RANDOM_WORDS)
			send_word(random_word());
		in_valid <= 1'b0;

		while (beats_pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("Sent %0d command words, %0d of them curves; checked %0d result beats.",
			words_seen, curve_words, beats_seen);
		if (beats_pending != 0)
			$display("%0d expected result beats never arrived", beats_pending);
		if (mismatches == 0 && beats_pending == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
